[rtl/core/assert_macros.svh]
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checked only out of reset.
`define ASSERT_RUN(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RUN(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[rtl/core/b2d_pkg.sv]
// Shared constants and types of the binary to decimal ASCII converter.
package b2d_pkg;

    localparam int NUMBER_BITS = 64;
    localparam int IN_BITS     = 64;
    // decimal digits needed: floor(bits * log10(2)) + 1
    localparam int NUM_DIGITS  = (NUMBER_BITS * 30103) / 100000 + 1;
    localparam int BCD_W       = NUM_DIGITS * 4;
    localparam int BIT_CNT_W   = $clog2(NUMBER_BITS);
    localparam int DIG_W       = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int CHAR_W      = 6;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

    typedef logic [NUMBER_BITS-1:0] t_num;

    // word handed from the front queue to the converter
    typedef struct packed {
        logic is_zero;
        t_num number;
    } t_item;

    // converter status seen by the top level
    typedef struct packed {
        logic idle;
        logic converting;
        logic emitting;
    } t_back_stat;

endpackage

[rtl/core/b2d_front.sv]
// Input side: masks and classifies each word, holds up to two in a small queue.
module b2d_front
    import b2d_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic [IN_BITS-1:0] i_number,
    output logic               o_item_valid,
    input  logic               i_item_ready,
    output t_item              o_item
);

    logic  r_head_v, n_head_v;
    logic  r_tail_v, n_tail_v;
    t_item r_head, n_head;
    t_item r_tail, n_tail;
    t_item w_in;
    logic  w_push;
    logic  w_pop;

    always_comb begin
        w_in.number  = i_number[NUMBER_BITS-1:0];
        w_in.is_zero = (w_in.number == '0);
    end

    assign o_full       = r_tail_v;
    assign o_item_valid = r_head_v;
    assign o_item       = r_head;
    assign w_push       = i_push && !r_tail_v;
    assign w_pop        = r_head_v && i_item_ready;

    always_comb begin
        n_head_v = r_head_v;
        n_tail_v = r_tail_v;
        n_head   = r_head;
        n_tail   = r_tail;
        if (w_pop) begin
            if (r_tail_v) begin
                n_head   = r_tail;
                n_tail_v = 1'b0;
            end else begin
                n_head   = w_in;
                n_head_v = w_push;
            end
        end else if (w_push) begin
            if (!r_head_v) begin
                n_head   = w_in;
                n_head_v = 1'b1;
            end else begin
                n_tail   = w_in;
                n_tail_v = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_v <= 1'b0;
            r_tail_v <= 1'b0;
        end else begin
            r_head_v <= n_head_v;
            r_tail_v <= n_tail_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_tail <= n_tail;
    end

endmodule

[rtl/core/b2d_back.sv]
// Converter: bit-serial double dabble, then digit emission into an output register.
module b2d_back
    import b2d_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_item_valid,
    output logic              o_item_ready,
    input  t_item             i_item,
    output logic              o_empty,
    input  logic              i_pop,
    output logic [CHAR_W-1:0] o_digit_char,
    output logic              o_last_digit,
    output t_back_stat        o_stat
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]           r_state, n_state;
    t_num                 r_bin, n_bin;
    logic [BCD_W-1:0]     r_bcd, n_bcd;
    logic [BIT_CNT_W-1:0] r_bit, n_bit;
    logic [DIG_W-1:0]     r_dig, n_dig;
    logic                 r_started, n_started;
    logic                 r_out_v, n_out_v;
    logic [CHAR_W-1:0]    r_char, n_char;
    logic                 r_last, n_last;

    logic [BCD_W-1:0] w_adj;
    logic [3:0]       w_top;
    logic             w_is_last;
    logic             w_show;
    logic             w_slot;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (r_bcd[d*4 +: 4] >= 4'd5) begin
                w_adj[d*4 +: 4] = r_bcd[d*4 +: 4] + 4'd3;
            end else begin
                w_adj[d*4 +: 4] = r_bcd[d*4 +: 4];
            end
        end
    end

    assign w_top     = r_bcd[BCD_W-1 -: 4];
    assign w_is_last = (r_dig == '0);
    assign w_show    = w_is_last || r_started || (w_top != 4'd0);
    assign w_slot    = !r_out_v || i_pop;

    assign o_item_ready = (r_state == ST_IDLE);
    assign o_empty      = !r_out_v;
    assign o_digit_char = r_char;
    assign o_last_digit = r_last;

    always_comb begin
        o_stat.idle       = (r_state == ST_IDLE);
        o_stat.converting = (r_state == ST_CONV);
        o_stat.emitting   = (r_state == ST_EMIT);
    end

    always_comb begin
        n_state   = r_state;
        n_bin     = r_bin;
        n_bcd     = r_bcd;
        n_bit     = r_bit;
        n_dig     = r_dig;
        n_started = r_started;
        n_out_v   = r_out_v && !i_pop;
        n_char    = r_char;
        n_last    = r_last;
        unique case (r_state)
            ST_IDLE: begin
                if (i_item_valid) begin
                    n_bin     = i_item.number;
                    n_bcd     = '0;
                    n_bit     = BIT_CNT_W'(NUMBER_BITS - 1);
                    n_dig     = DIG_W'(NUM_DIGITS - 1);
                    n_started = 1'b0;
                    // zero needs no conversion: the cleared digits already read 0
                    n_state   = i_item.is_zero ? ST_EMIT : ST_CONV;
                end
            end
            ST_CONV: begin
                n_bcd = {w_adj[BCD_W-2:0], r_bin[NUMBER_BITS-1]};
                n_bin = r_bin << 1;
                if (r_bit == '0) begin
                    n_state = ST_EMIT;
                end else begin
                    n_bit = r_bit - 1'b1;
                end
            end
            ST_EMIT: begin
                if (!w_show) begin
                    // leading zero: drop it without using the output slot
                    n_bcd = r_bcd << 4;
                    n_dig = r_dig - 1'b1;
                end else if (w_slot) begin
                    n_out_v   = 1'b1;
                    n_char    = ASCII_ZERO + {{(CHAR_W-4){1'b0}}, w_top};
                    n_last    = w_is_last;
                    n_started = 1'b1;
                    n_bcd     = r_bcd << 4;
                    n_dig     = r_dig - 1'b1;
                    if (w_is_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin     <= n_bin;
        r_bcd     <= n_bcd;
        r_bit     <= n_bit;
        r_dig     <= n_dig;
        r_started <= n_started;
        r_char    <= n_char;
        r_last    <= n_last;
    end

endmodule

[rtl/core/binary_to_decimal_ascii.sv]
// Top level of the unsigned binary to decimal ASCII converter.
//
//  Channel   Handshake        Payload                         Direction
//  input     i_push / o_full  i_number[63:0]                  in
//  result    o_empty / i_pop  o_digit_char[5:0], o_last_digit out
//
//  Each input word becomes 1 to 20 result words, most significant digit first,
//  o_last_digit set on the final one; the value zero gives a single '0'.
//  Per word: a load step, the double-dabble loop over all 64 bits (skipped for
//  zero), then the 20 digit positions one at a time, leading zeros dropped.
//  The front queue holds two words, so input is still taken during a conversion until it fills;
//  a stalled pop freezes emission only, not the conversion already underway.
//  Reset (i_rst_n low, synchronous) empties the queue and the result register.
`include "assert_macros.svh"

module binary_to_decimal_ascii
    import b2d_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic [IN_BITS-1:0] i_number,
    output logic               o_empty,
    input  logic               i_pop,
    output logic [CHAR_W-1:0]  o_digit_char,
    output logic               o_last_digit
);

    logic       w_item_valid;
    logic       w_item_ready;
    t_item      w_item;
    t_back_stat w_stat;

    // front: masking, zero detect, two-word queue
    b2d_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_number     (i_number),
        .o_item_valid (w_item_valid),
        .i_item_ready (w_item_ready),
        .o_item       (w_item)
    );

    // back: conversion and digit output
    b2d_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_item_valid),
        .o_item_ready (w_item_ready),
        .i_item       (w_item),
        .o_empty      (o_empty),
        .i_pop        (i_pop),
        .o_digit_char (o_digit_char),
        .o_last_digit (o_last_digit),
        .o_stat       (w_stat)
    );

    // a handed-over word always starts a conversion or an emission
    `ASSERT_RUN(a_hand_busy, i_clk, i_rst_n, (w_item_valid && w_item_ready) |=> !w_stat.idle, "converter idle after handoff")
    // once the converter is idle, only the final digit of a run can still wait
    `ASSERT_RUN(a_idle_last, i_clk, i_rst_n, (w_stat.idle && !o_empty) |-> o_last_digit, "non-final digit left behind")
    // zero words skip the conversion loop
    `ASSERT_RUN(a_zero_skip, i_clk, i_rst_n, (w_item_valid && w_item_ready && w_item.is_zero) |=> w_stat.emitting, "zero word entered conversion")
    // no handoff while the shift loop runs
    `ASSERT_RUN(a_conv_busy, i_clk, i_rst_n, w_stat.converting |-> !w_item_ready, "converter ready mid-conversion")
    // reset leaves no result pending
    `ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> o_empty, "result pending after reset")

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the binary to decimal ASCII converter.
module tb_top
    import b2d_pkg::*;
();

    // Run limits. The slowest legal run is roughly 374 words x 20 digits, each digit
    // behind the longest pop stall, plus conversion time; CYCLE_LIMIT lies above it.
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES  = 1500;     // long receiver hold-off
    localparam int RAND_WORDS   = 340;
    localparam int PRINT_LIMIT  = 40;

    // One expected digit word.
    typedef struct packed {
        logic [IN_BITS-1:0] src;        // number it came from, for messages
        logic [CHAR_W-1:0]  chr;
        logic               is_last;
    } t_digit_word;

    // Directed row. An empty text means the predictor supplies the digits.
    typedef struct {
        logic [IN_BITS-1:0] number;
        string              text;
    } t_dir_row;

    logic               i_clk;
    logic               i_rst_n      = 1'b0;
    logic               i_push       = 1'b0;
    logic [IN_BITS-1:0] i_number     = '0;
    logic               i_pop        = 1'b0;
    logic               o_full;
    logic               o_empty;
    logic [CHAR_W-1:0]  o_digit_char;
    logic               o_last_digit;

    t_digit_word pending_digits[$];     // digits still owed by the block
    int          mismatches    = 0;
    int          cycle_count   = 0;
    bit          quiet_mode    = 1'b0;  // no idling on either side
    bit          hold_request  = 1'b0;  // asks the receiver for a long hold-off

    // Extremes, zero, digit-count boundaries and bit patterns.
    t_dir_row dir_rows[] = '{
        '{64'd0,                    "0"},
        '{64'd1,                    "1"},
        '{64'd9,                    "9"},
        '{64'd10,                   "10"},
        '{64'd99,                   "99"},
        '{64'd100,                  "100"},
        '{64'd0,                    "0"},
        '{64'd123456789,            "123456789"},
        '{64'hFFFF_FFFF,            "4294967295"},
        '{64'h7FFF_FFFF_FFFF_FFFF,  "9223372036854775807"},
        '{64'h8000_0000_0000_0000,  "9223372036854775808"},
        '{64'd9999999999999999999,  "9999999999999999999"},
        '{64'd10000000000000000000, "10000000000000000000"},
        '{64'd12345678901234567890, "12345678901234567890"},
        '{64'hFFFF_FFFF_FFFF_FFFF,  "18446744073709551615"},
        '{64'hFFFF_FFFF_FFFF_FFFE,  ""},
        '{64'h5555_5555_5555_5555,  ""},
        '{64'hAAAA_AAAA_AAAA_AAAA,  ""},
        '{64'h0123_4567_89AB_CDEF,  ""},
        '{64'd1000000,              ""},
        '{64'd0,                    "0"},
        '{64'hFFFF_FFFF_FFFF_FFFF,  "18446744073709551615"}
    };

    binary_to_decimal_ascii i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_number     (i_number),
        .o_empty      (o_empty),
        .i_pop        (i_pop),
        .o_digit_char (o_digit_char),
        .o_last_digit (o_last_digit)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_LIMIT) begin
            $display("MISMATCH at %0t: %s", $time, what);
        end
        mismatches++;
    endtask

    // Decimal expansion: peel digits off the low end, so the queue gets them
    // MSB first; a zero value still yields one '0' because of the do-while.
    function automatic void predict_decimal(input logic [IN_BITS-1:0] raw);
        t_num        val;
        t_digit_word run[$];
        t_digit_word w;
        val = t_num'(raw);              // bits above NUMBER_BITS are dropped
        do begin
            w.src     = raw;
            w.chr     = ASCII_ZERO + CHAR_W'(val % 10);
            w.is_last = 1'b0;
            run.push_front(w);
            val = val / 10;
        end while (val != 0);
        run[run.size()-1].is_last = 1'b1;
        foreach (run[k]) pending_digits.push_back(run[k]);
    endfunction

    // Idle length: mostly none or short, now and then a long one.
    function automatic int idle_gap();
        int r;
        if (quiet_mode) return 0;
        r = $urandom_range(0, 15);
        if (r < 8)  return 0;
        if (r < 14) return $urandom_range(1, 3);
        return $urandom_range(20, 80);
    endfunction

    // Random number: zeros, values around powers of ten, full-width values
    // and values of random bit length so every digit count shows up.
    function automatic logic [IN_BITS-1:0] pick_number();
        logic [IN_BITS-1:0] v;
        logic [IN_BITS-1:0] p10;
        int                 kind;
        kind = $urandom_range(0, 9);
        v    = {$urandom, $urandom};
        if (kind == 0) begin
            v = '0;
        end else if (kind <= 2) begin
            p10 = 64'd1;
            repeat ($urandom_range(0, 19)) p10 = p10 * 10;
            v = p10 + 64'($urandom_range(0, 2)) - 64'd1;
        end else if (kind >= 6) begin
            v = v >> (64 - $urandom_range(1, 64));
        end
        return v;
    endfunction

    // Called at a rising edge. Optionally idles, then offers the word and
    // returns at the edge where it is accepted.
    task automatic send_number(input logic [IN_BITS-1:0] num, input string text,
                               input bit may_idle);
        int          gap;
        t_digit_word w;
        gap = may_idle ? idle_gap() : 0;
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_push   <= 1'b1;
        i_number <= num;
        do @(posedge i_clk); while (o_full !== 1'b0);
        if (text.len() != 0) begin
            // typed-in answer: characters map straight to 6-bit codes
            for (int k = 0; k < text.len(); k++) begin
                w.src     = num;
                w.chr     = CHAR_W'(text[k]);
                w.is_last = (k == text.len() - 1);
                pending_digits.push_back(w);
            end
        end else begin
            predict_decimal(num);
        end
    endtask

    task automatic wait_drained();
        while (pending_digits.size() != 0) @(posedge i_clk);
    endtask

    // Result side: checks every accepted digit word against the oldest expectation.
    always @(posedge i_clk) begin
        t_digit_word exp_w;
        if (i_rst_n && i_pop && o_empty === 1'b0) begin
            if (pending_digits.size() == 0) begin
                report_mismatch($sformatf("unexpected digit word %0d last=%0b",
                                          o_digit_char, o_last_digit));
            end else begin
                exp_w = pending_digits.pop_front();
                if (o_digit_char !== exp_w.chr) begin
                    report_mismatch($sformatf("number %0d: digit_char %0d, expected %0d",
                                              exp_w.src, o_digit_char, exp_w.chr));
                end
                if (o_last_digit !== exp_w.is_last) begin
                    report_mismatch($sformatf("number %0d: last_digit %0b, expected %0b",
                                              exp_w.src, o_last_digit, exp_w.is_last));
                end
            end
        end
    end

    // Receiver pacing. Pop goes low for a random gap after each accepted word,
    // and for HOLD_CYCLES when the stimulus asks for the long hold-off.
    initial begin
        int pop_gap;
        int hold_left;
        pop_gap   = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                i_pop <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                i_pop <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
                i_pop <= 1'b0;
            end else if (pop_gap > 0) begin
                pop_gap--;
                i_pop <= (pop_gap == 0);
            end else if (i_pop && o_empty === 1'b0) begin
                pop_gap = idle_gap();
                i_pop <= (pop_gap == 0);
            end else begin
                i_pop <= 1'b1;
            end
        end
    end

    // Hard stop for a hung handshake.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Stimulus
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (dir_rows[r]) begin
            send_number(dir_rows[r].number, dir_rows[r].text, 1'b1);
        end

        // sender pauses until every digit is out
        i_push <= 1'b0;
        wait_drained();
        @(posedge i_clk);

        // receiver holds off while the sender keeps offering back to back,
        // so the front queue fills and o_full pushes back
        hold_request = 1'b1;
        repeat (12) send_number(pick_number(), "", 1'b0);

        // random traffic, with one stretch where nobody idles
        for (int n = 0; n < RAND_WORDS; n++) begin
            quiet_mode = (n >= 120 && n < 160);
            send_number(pick_number(), "", 1'b1);
        end
        quiet_mode = 1'b0;
        i_push <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_digits.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
